FILE: rtl/core/rrjs_pkg.sv
package rrjs_pkg;

    // Operation codes carried in s_tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Field widths fixed by the stream format.
    localparam int SLOT_FIELD_W = 3;
    localparam int NEED_FIELD_W = 8;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 8;

    // One scheduling result as it is packed into m_tdata.
    typedef struct packed {
        logic                    all_done;
        logic                    slot_finished;
        logic [SLOT_FIELD_W-1:0] served_slot;
        logic                    served_valid;
    } result_t;

endpackage

FILE: rtl/core/round_robin_job_scheduler_unit.sv
// A load transaction goes from IDLE straight to EMIT; a tick goes through SEARCH, which walks
// the ring one slot per cycle, then UPDATE, then EMIT. EMIT hands the result to the output register.
// One transaction at a time: a new one is accepted only in IDLE, once EMIT has passed the last
// result on; EMIT waits while the result side stalls. The registered read adds UPDATE to a tick.
// Reset (aresetn low, synchronous): every slot ended, ring pointer zero, output empty.
// The slot memory itself is not cleared; it is only read for slots that were loaded.
module round_robin_job_scheduler_unit #(
    parameter int SLOTS      = 8,
    parameter int COUNT_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rrjs_pkg::S_TDATA_W-1:0] s_tdata,  // [2:0] slot, [10:3] need_time, rest zero
    input  logic [0:0]                     s_tuser,  // [0] operation (0 load, 1 tick)
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rrjs_pkg::M_TDATA_W-1:0] m_tdata   // [0] served_valid, [3:1] served_slot,
                                                     // [4] slot_finished, [5] all_done,
                                                     // [7:6] zero
);

    import rrjs_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ENTRY_W = 2 * COUNT_BITS;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    logic [1:0]        state_reg, state_next;
    logic [SLOTS-1:0]  run_reg, run_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic [SLOT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [SLOT_W-1:0] scan_cnt_reg, scan_cnt_next;

    // Result waiting for the output register.
    logic              res_valid_reg, res_valid_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_fin_reg, res_fin_next;

    logic              m_tvalid_reg, m_tvalid_next;
    result_t           m_tdata_reg, m_tdata_next;

    // Input field decode.
    logic                  in_accept;
    logic                  in_op;
    logic [31:0]           slot_wide;
    logic [31:0]           need_wide;
    logic                  slot_in_ring;
    logic [SLOT_W-1:0]     load_idx;
    logic [COUNT_BITS-1:0] need_in;

    // Slot memory: need count in the upper half, served count in the lower half.
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [COUNT_BITS-1:0] ent_need;
    logic [COUNT_BITS-1:0] ent_served_inc;
    logic                  ent_finish;

    logic                  out_free;
    logic [31:0]           res_slot_wide;

    assign in_accept    = s_tvalid && s_tready;
    assign in_op        = s_tuser[0];
    assign slot_wide    = 32'(s_tdata[SLOT_FIELD_W-1:0]);
    assign need_wide    = 32'(s_tdata[SLOT_FIELD_W +: NEED_FIELD_W]);
    assign slot_in_ring = slot_wide < 32'(SLOTS);
    assign load_idx     = slot_wide[SLOT_W-1:0];
    // Only the low COUNT_BITS bits of the need are kept.
    assign need_in      = need_wide[COUNT_BITS-1:0];

    assign ent_need       = ram_rdata[ENTRY_W-1:COUNT_BITS];
    assign ent_served_inc = ram_rdata[COUNT_BITS-1:0] + COUNT_BITS'(1);
    assign ent_finish     = ent_served_inc == ent_need;

    // Only one transaction is in flight, so a write-back always lands before the
    // next read of any entry and no forwarding path is needed.
    assign ram_re = (state_reg == ST_SEARCH) && run_reg[scan_idx_reg];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = load_idx;
        ram_wdata = {need_in, COUNT_BITS'(0)};
        if (state_reg == ST_IDLE) begin
            ram_we = in_accept && (in_op == OP_LOAD) && slot_in_ring;
        end else if (state_reg == ST_UPDATE) begin
            ram_we    = 1'b1;
            ram_waddr = scan_idx_reg;
            ram_wdata = {ent_need, ent_served_inc};
        end
    end

    rrjs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rdata)
    );

    assign out_free      = !m_tvalid_reg || m_tready;
    assign res_slot_wide = 32'(res_slot_reg);

    // Sequencer: a load updates its slot in IDLE, then goes to EMIT; a tick walks the ring one slot per cycle
    // from the pointer, reads the first running slot and writes back its served count, or finds none; then EMIT.
    always_comb begin
        state_next     = state_reg;
        run_next       = run_reg;
        ptr_next       = ptr_reg;
        scan_idx_next  = scan_idx_reg;
        scan_cnt_next  = scan_cnt_reg;
        res_valid_next = res_valid_reg;
        res_slot_next  = res_slot_reg;
        res_fin_next   = res_fin_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    res_valid_next = 1'b0;
                    res_slot_next  = '0;
                    res_fin_next   = 1'b0;
                    scan_idx_next  = ptr_reg;
                    scan_cnt_next  = '0;
                    if (in_op == OP_LOAD) begin
                        // A load of a slot outside the ring changes nothing.
                        if (slot_in_ring) begin
                            run_next[load_idx] = |need_in;
                        end
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (run_reg[scan_idx_reg]) begin
                    state_next = ST_UPDATE;
                end else if (scan_cnt_reg == LAST_SLOT) begin
                    // Whole ring ended: empty result, pointer unchanged.
                    state_next = ST_EMIT;
                end else begin
                    scan_idx_next = (scan_idx_reg == LAST_SLOT) ? '0
                                                                : scan_idx_reg + SLOT_W'(1);
                    scan_cnt_next = scan_cnt_reg + SLOT_W'(1);
                end
            end
            ST_UPDATE: begin
                res_valid_next = 1'b1;
                res_slot_next  = scan_idx_reg;
                res_fin_next   = ent_finish;
                if (ent_finish) begin
                    run_next[scan_idx_reg] = 1'b0;
                end
                ptr_next   = (scan_idx_reg == LAST_SLOT) ? '0 : scan_idx_reg + SLOT_W'(1);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: takes the pending result once it is free or being drained.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if ((state_reg == ST_EMIT) && out_free) begin
            m_tvalid_next              = 1'b1;
            m_tdata_next.served_valid  = res_valid_reg;
            m_tdata_next.served_slot   = res_slot_wide[SLOT_FIELD_W-1:0];
            m_tdata_next.slot_finished = res_fin_reg;
            // Flags do not change in EMIT, so they already reflect this transaction.
            m_tdata_next.all_done      = ~|run_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            run_reg      <= '0;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            run_reg      <= run_next;
            ptr_reg      <= ptr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg  <= scan_idx_next;
        scan_cnt_reg  <= scan_cnt_next;
        res_valid_reg <= res_valid_next;
        res_slot_reg  <= res_slot_next;
        res_fin_reg   <= res_fin_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_tdata_reg);

`ifndef SYNTH
    // The slot being written back must be the running slot the search stopped on.
    a_update_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) && run_reg[scan_idx_reg] |=>
            (state_reg == ST_UPDATE) && run_reg[scan_idx_reg])
        else $error("write-back of a slot that is not running");

    // An empty result carries no slot and no finish mark.
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[4:1] == 4'd0))
        else $error("empty result with slot or finish bits set");

    // A served slot that did not finish is still running, so the ring cannot be done.
    a_done_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] && !m_tdata[4] |-> !m_tdata[5])
        else $error("all_done reported while the served slot still runs");
`endif

endmodule

FILE: rtl/core/rrjs_ram.sv
module rrjs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rrjs_pkg::*;

    localparam int SLOTS       = 8;
    localparam int ITEM_TARGET = 1650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 16;   // a little more than the slowest tick latency
    localparam int IDLE_PCT    = 22;

    // One row of the directed table. When typed is set, the want_* columns give the
    // result that the row must produce; otherwise the scheduler prediction is used.
    typedef struct {
        logic       op;
        logic [2:0] slot;
        logic [7:0] need;
        bit         typed;
        bit         want_valid;
        logic [2:0] want_slot;
        bit         want_fin;
        bit         want_all;
    } stim_row_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser  = OP_LOAD;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the scheduler state, updated at every accepted input transaction.
    logic [7:0]       need_mem   [SLOTS];
    logic [7:0]       served_mem [SLOTS];
    logic [SLOTS-1:0] running;
    logic [2:0]       ring_ptr;

    result_t pending_results [$];
    int      mismatches  = 0;
    int      items_sent  = 0;
    int      cycle_count = 0;
    bit      quiet       = 1'b0;   // set during a stretch where neither side idles

    stim_row_t directed_rows [23] = '{
        // A tick right after reset finds an empty ring.
        '{OP_TICK, 3'd0, 8'd0,   1'b1, 1'b0, 3'd0, 1'b0, 1'b1},
        // A zero need ends the slot at once, so the ring stays empty.
        '{OP_LOAD, 3'd0, 8'd0,   1'b1, 1'b0, 3'd0, 1'b0, 1'b1},
        '{OP_LOAD, 3'd7, 8'd255, 1'b1, 1'b0, 3'd0, 1'b0, 1'b0},
        // The search starts at slot 0 and has to walk all the way to slot 7.
        '{OP_TICK, 3'd0, 8'd0,   1'b1, 1'b1, 3'd7, 1'b0, 1'b0},
        // Reloading a running slot restarts it with the new need.
        '{OP_LOAD, 3'd7, 8'd1,   1'b1, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_TICK, 3'd0, 8'd0,   1'b1, 1'b1, 3'd7, 1'b1, 1'b1},
        // Empty ring again; the pointer must not move.
        '{OP_TICK, 3'd0, 8'd0,   1'b1, 1'b0, 3'd0, 1'b0, 1'b1},
        '{OP_LOAD, 3'd3, 8'd2,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_LOAD, 3'd5, 8'd1,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_LOAD, 3'd6, 8'd170, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_TICK, 3'd0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_TICK, 3'd0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_TICK, 3'd0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        // The pointer wraps from slot 7 back around to slot 3.
        '{OP_TICK, 3'd0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        // Loading zero into a running slot ends it.
        '{OP_LOAD, 3'd6, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_LOAD, 3'd1, 8'd85,  1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_LOAD, 3'd2, 8'd1,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_LOAD, 3'd4, 8'd1,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_TICK, 3'd0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_TICK, 3'd0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_TICK, 3'd0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_LOAD, 3'd1, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0, 1'b0},
        '{OP_TICK, 3'd5, 8'd255, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0}
    };

    round_robin_job_scheduler_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [2:0] slot, [10:3] need_time, [15:11] zero
        .s_tuser  (s_tuser),   // [0] operation
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [0] served_valid, [3:1] served_slot, [4] slot_finished,
                               // [5] all_done, [7:6] zero
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Applies one transaction to the shadow state and returns the result it must produce.
    // A load resets the slot's service; a tick walks the ring from the pointer and serves
    // the first running slot, or reports an empty ring and leaves the pointer alone.
    function automatic result_t schedule_step(input logic op, input logic [2:0] slot,
                                              input logic [7:0] need);
        result_t    res;
        logic [2:0] idx;
        bit         found;
        res   = '0;
        found = 1'b0;
        if (op == OP_LOAD) begin
            need_mem[slot]   = need;
            served_mem[slot] = '0;
            running[slot]    = (need != 8'd0);
        end else begin
            for (int k = 0; k < SLOTS; k++) begin
                idx = ring_ptr + 3'(k);
                if (!found && running[idx]) begin
                    found           = 1'b1;
                    served_mem[idx] = served_mem[idx] + 8'd1;
                    if (served_mem[idx] == need_mem[idx]) begin
                        running[idx]      = 1'b0;
                        res.slot_finished = 1'b1;
                    end
                    res.served_valid = 1'b1;
                    res.served_slot  = idx;
                    ring_ptr         = idx + 3'd1;
                end
            end
        end
        res.all_done = (running == '0);
        return res;
    endfunction

    // Drives one input transaction from the falling edge, with random idle cycles ahead of
    // it, and records its expected result once the handshake completes.
    task automatic send_item(input logic op, input logic [2:0] slot, input logic [7:0] need,
                             input bit typed, input result_t want);
        result_t predicted;
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, need, slot};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predicted = schedule_step(op, slot, need);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // The result side stalls at random, except during the quiet stretch.
    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Every accepted result transaction is matched against the oldest expectation.
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[5:0]);
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction, m_tdata %02h", m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.served_valid !== want.served_valid) begin
                    $error("served_valid: expected %0d, got %0d",
                           want.served_valid, got.served_valid);
                    mismatches++;
                end
                if (got.served_slot !== want.served_slot) begin
                    $error("served_slot: expected %0d, got %0d",
                           want.served_slot, got.served_slot);
                    mismatches++;
                end
                if (got.slot_finished !== want.slot_finished) begin
                    $error("slot_finished: expected %0d, got %0d",
                           want.slot_finished, got.slot_finished);
                    mismatches++;
                end
                if (got.all_done !== want.all_done) begin
                    $error("all_done: expected %0d, got %0d", want.all_done, got.all_done);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        result_t    want;
        int         n_loads;
        int         n_ticks;
        int         pick;
        logic [2:0] slot;
        logic [7:0] need;

        for (int i = 0; i < SLOTS; i++) begin
            need_mem[i]   = '0;
            served_mem[i] = '0;
        end
        running  = '0;
        ring_ptr = '0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table: extremes of every field and each corner of the ring search.
        foreach (directed_rows[i]) begin
            want               = '0;
            want.served_valid  = directed_rows[i].want_valid;
            want.served_slot   = directed_rows[i].want_slot;
            want.slot_finished = directed_rows[i].want_fin;
            want.all_done      = directed_rows[i].want_all;
            send_item(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].need,
                      directed_rows[i].typed, want);
        end

        // Random part: bursts of loads followed by runs of ticks. Needs are mostly short so
        // that slots finish and the ring drains often; zero needs and full-range needs are
        // mixed in so that every need bit toggles and long-running slots appear.
        while (items_sent < ITEM_TARGET) begin
            n_loads = $urandom_range(1, 6);
            n_ticks = $urandom_range(1, 24);
            for (int i = 0; i < n_loads; i++) begin
                quiet = (items_sent >= 700 && items_sent < 1000);
                slot  = 3'($urandom_range(SLOTS - 1));
                pick  = $urandom_range(99);
                if (pick < 10) begin
                    need = 8'd0;
                end else if (pick < 75) begin
                    need = 8'($urandom_range(1, 5));
                end else if (pick < 90) begin
                    need = 8'($urandom_range(6, 40));
                end else begin
                    need = 8'($urandom_range(255));
                end
                send_item(OP_LOAD, slot, need, 1'b0, '0);
            end
            for (int i = 0; i < n_ticks; i++) begin
                quiet = (items_sent >= 700 && items_sent < 1000);
                // The slot and need fields of a tick carry junk; the block must ignore them.
                send_item(OP_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)), 1'b0, '0);
            end
        end
        quiet = 1'b0;

        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
